/* design/region_masked_grayscale_macros.svh */
// ----------------------------------------------------------------------------
// Region-masked grayscale assertion macros
// Shared concurrent assertion forms for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef REGION_MASKED_GRAYSCALE_MACROS_SVH
`define REGION_MASKED_GRAYSCALE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rmg_pkg.sv */
// ----------------------------------------------------------------------------
// Region-masked grayscale package
// Widths, register codes, region modes and pipeline stage records.
// ----------------------------------------------------------------------------
package rmg_pkg;

   // Field widths.
   localparam int DIM_W    = 13;   // frame size register width
   localparam int COORD_W  = 12;   // column and row width
   localparam int CHAN_W   = 8;    // one color channel
   localparam int CSR_IDX_W = 2;

   // Largest frame dimension; dimensions are clamped to [2, MAX_DIM].
   localparam int MAX_DIM  = 4096;
   localparam int SPAN_W   = $clog2(MAX_DIM);     // a = W-1, b = H-1
   localparam int OFS_W    = COORD_W + 1;         // |2*column - k*a|
   localparam int PROD_W   = OFS_W + SPAN_W;      // offset times span
   localparam int AB_W     = 2 * SPAN_W;          // a*b
   localparam int ABSQ_W   = 2 * AB_W;            // (a*b)^2
   localparam int SQ_W     = 2 * PROD_W;          // squared scaled offset
   localparam int SUM_W    = CHAN_W + 2;          // b + g + r

   // Division by three: floor(s/3) = (s*683) >> 11 for every s below 2048.
   localparam int GRAY_SHIFT = 11;
   localparam logic [SUM_W-1:0] GRAY_RECIP = SUM_W'(683);
   localparam int GRAY_PROD_W = 2 * SUM_W;

   // Register reset values and the constants derived from them.
   localparam logic [DIM_W-1:0]  DIM_RESET   = DIM_W'(512);
   localparam logic [SPAN_W-1:0] SPAN_RESET  = SPAN_W'(511);
   localparam logic [AB_W-1:0]   AB_RESET    = AB_W'(SPAN_RESET) * AB_W'(SPAN_RESET);
   localparam logic [ABSQ_W-1:0] ABSQ_RESET  = ABSQ_W'(AB_RESET) * ABSQ_W'(AB_RESET);

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_REGION_MODE  = 2'd2
   } csr_index_type;

   // Region shapes.
   typedef enum logic [1:0] {
      MODE_DIAMOND = 2'd0,
      MODE_CORNERS = 2'd1,
      MODE_CIRCLE  = 2'd2
   } region_mode_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      region_mode_type     mode;
      logic [SPAN_W-1:0]   span_x;   // W-1
      logic [SPAN_W-1:0]   span_y;   // H-1
      logic [AB_W-1:0]     ab;
      logic [ABSQ_W-1:0]   ab_sq;
   } cfg_type;

   // Per-stage load enables.
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
      logic load_s4;
   } pipe_ctl_type;

   // Stage 1: absolute offsets and channel sum.
   typedef struct packed {
      logic [OFS_W-1:0]  x0;
      logic [OFS_W-1:0]  x1;
      logic [OFS_W-1:0]  y0;
      logic [OFS_W-1:0]  y1;
      logic [SUM_W-1:0]  sum;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } s1_type;

   // Stage 2: scaled offsets and gray mean.
   typedef struct packed {
      logic [PROD_W-1:0] px0;
      logic [PROD_W-1:0] px1;
      logic [PROD_W-1:0] qy0;
      logic [PROD_W-1:0] qy1;
      logic [CHAN_W-1:0] mean;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } s2_type;

   // Stage 3: squared offsets and the diamond decision.
   typedef struct packed {
      logic [SQ_W-1:0]   sx0;
      logic [SQ_W-1:0]   sx1;
      logic [SQ_W-1:0]   sy0;
      logic [SQ_W-1:0]   sy1;
      logic              diamond_out;
      logic [CHAN_W-1:0] mean;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } s3_type;

   // Result pixel.
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              made_gray;
   } out_type;

endpackage

/* design/rmg_csr.sv */
// ----------------------------------------------------------------------------
// Region-masked grayscale configuration registers
// Holds frame size and mode, and precomputes the clamped spans, their
// product and its square one register apart so each is ready before the
// pipeline stage that reads it.
// ----------------------------------------------------------------------------
module rmg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [rmg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rmg_pkg::DIM_W-1:0]    csr_wdata,
   output rmg_pkg::cfg_type             cfg
);

   logic [rmg_pkg::DIM_W-1:0]    width_ff;
   logic [rmg_pkg::DIM_W-1:0]    height_ff;
   rmg_pkg::region_mode_type     mode_ff;
   logic [rmg_pkg::SPAN_W-1:0]   span_x_ff;
   logic [rmg_pkg::SPAN_W-1:0]   span_y_ff;
   logic [rmg_pkg::AB_W-1:0]     ab_ff;
   logic [rmg_pkg::ABSQ_W-1:0]   ab_sq_ff;
   logic [rmg_pkg::SPAN_W-1:0]   span_x_in;
   logic [rmg_pkg::SPAN_W-1:0]   span_y_in;
   logic [rmg_pkg::DIM_W-1:0]    width_in;
   logic [rmg_pkg::DIM_W-1:0]    height_in;
   logic [rmg_pkg::DIM_W-1:0]    width_clamp;
   logic [rmg_pkg::DIM_W-1:0]    height_clamp;

   localparam logic [rmg_pkg::DIM_W-1:0] DIM_MIN = rmg_pkg::DIM_W'(2);
   localparam logic [rmg_pkg::DIM_W-1:0] DIM_MAX = rmg_pkg::DIM_W'(rmg_pkg::MAX_DIM);

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rmg_pkg::DIM_RESET;
         height_ff <= rmg_pkg::DIM_RESET;
         mode_ff   <= rmg_pkg::MODE_DIAMOND;
      end else if (csr_we) begin
         case (csr_index)
            rmg_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            rmg_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            rmg_pkg::CSR_REGION_MODE:  mode_ff   <= rmg_pkg::region_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // Clamp each dimension to the supported range and take one off. The
   // spans follow a write in the same cycle as the size registers do.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && (csr_index == rmg_pkg::CSR_FRAME_WIDTH)) width_in = csr_wdata;
      if (csr_we && (csr_index == rmg_pkg::CSR_FRAME_HEIGHT)) height_in = csr_wdata;
      if (width_in < DIM_MIN) width_clamp = DIM_MIN;
      else if (width_in > DIM_MAX) width_clamp = DIM_MAX;
      else width_clamp = width_in;
      if (height_in < DIM_MIN) height_clamp = DIM_MIN;
      else if (height_in > DIM_MAX) height_clamp = DIM_MAX;
      else height_clamp = height_in;
      span_x_in = rmg_pkg::SPAN_W'(width_clamp - rmg_pkg::DIM_W'(1));
      span_y_in = rmg_pkg::SPAN_W'(height_clamp - rmg_pkg::DIM_W'(1));
   end

   // Derived constants: the clamped spans, then one multiplication per register.
   always_ff @(posedge clock) begin
      if (reset) begin
         span_x_ff <= rmg_pkg::SPAN_RESET;
         span_y_ff <= rmg_pkg::SPAN_RESET;
         ab_ff     <= rmg_pkg::AB_RESET;
         ab_sq_ff  <= rmg_pkg::ABSQ_RESET;
      end else begin
         span_x_ff <= span_x_in;
         span_y_ff <= span_y_in;
         ab_ff     <= rmg_pkg::AB_W'(span_x_ff) * rmg_pkg::AB_W'(span_y_ff);
         ab_sq_ff  <= rmg_pkg::ABSQ_W'(ab_ff) * rmg_pkg::ABSQ_W'(ab_ff);
      end
   end

   assign cfg.mode   = mode_ff;
   assign cfg.span_x = span_x_ff;
   assign cfg.span_y = span_y_ff;
   assign cfg.ab     = ab_ff;
   assign cfg.ab_sq  = ab_sq_ff;

endmodule

/* design/rmg_front.sv */
// ----------------------------------------------------------------------------
// Region-masked grayscale front stages
// Stage 1 forms the absolute centre or corner offsets and the channel sum.
// Stage 2 scales the offsets by the opposite span and divides the sum by 3.
// ----------------------------------------------------------------------------
module rmg_front (
   input  logic                        clock,
   input  rmg_pkg::pipe_ctl_type       ctl,
   input  rmg_pkg::cfg_type            cfg,
   input  logic [rmg_pkg::COORD_W-1:0] column,
   input  logic [rmg_pkg::COORD_W-1:0] row,
   input  logic [rmg_pkg::CHAN_W-1:0]  blue_in,
   input  logic [rmg_pkg::CHAN_W-1:0]  green_in,
   input  logic [rmg_pkg::CHAN_W-1:0]  red_in,
   output rmg_pkg::s2_type             s2
);

   localparam int CTR_W = rmg_pkg::OFS_W + 1;   // signed 2*pos - span
   localparam int EDG_W = rmg_pkg::OFS_W + 2;   // signed 2*pos - 2*span

   rmg_pkg::s1_type s1_in, s1_ff;
   rmg_pkg::s2_type s2_in, s2_ff;

   logic [rmg_pkg::OFS_W-1:0]     ux, uy;
   logic signed [CTR_W-1:0]       cx, cy;
   logic signed [EDG_W-1:0]       ex, ey;
   logic [rmg_pkg::OFS_W-1:0]     cx_abs, cy_abs, ex_abs, ey_abs;
   logic [rmg_pkg::GRAY_PROD_W-1:0] gray_prod;

   // Offsets from the centre and from the far edges, doubled.
   always_comb begin
      ux = {column, 1'b0};
      uy = {row, 1'b0};
      cx = $signed({1'b0, ux}) - $signed({2'b00, cfg.span_x});
      cy = $signed({1'b0, uy}) - $signed({2'b00, cfg.span_y});
      ex = $signed({2'b00, ux}) - $signed({2'b00, cfg.span_x, 1'b0});
      ey = $signed({2'b00, uy}) - $signed({2'b00, cfg.span_y, 1'b0});
      cx_abs = cx[CTR_W-1] ? rmg_pkg::OFS_W'(-cx) : rmg_pkg::OFS_W'(cx);
      cy_abs = cy[CTR_W-1] ? rmg_pkg::OFS_W'(-cy) : rmg_pkg::OFS_W'(cy);
      ex_abs = ex[EDG_W-1] ? rmg_pkg::OFS_W'(-ex) : rmg_pkg::OFS_W'(ex);
      ey_abs = ey[EDG_W-1] ? rmg_pkg::OFS_W'(-ey) : rmg_pkg::OFS_W'(ey);
   end

   // Corner mode measures from both edges; the other shapes from the centre.
   always_comb begin
      if (cfg.mode == rmg_pkg::MODE_CORNERS) begin
         s1_in.x0 = ux;
         s1_in.x1 = ex_abs;
         s1_in.y0 = uy;
         s1_in.y1 = ey_abs;
      end else begin
         s1_in.x0 = cx_abs;
         s1_in.x1 = cx_abs;
         s1_in.y0 = cy_abs;
         s1_in.y1 = cy_abs;
      end
      s1_in.sum   = rmg_pkg::SUM_W'(blue_in) + rmg_pkg::SUM_W'(green_in)
                  + rmg_pkg::SUM_W'(red_in);
      s1_in.blue  = blue_in;
      s1_in.green = green_in;
      s1_in.red   = red_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         s1_ff <= s1_in;
      end
   end

   // Scale x offsets by H-1 and y offsets by W-1; gray mean by reciprocal.
   always_comb begin
      s2_in.px0 = rmg_pkg::PROD_W'(s1_ff.x0) * rmg_pkg::PROD_W'(cfg.span_y);
      s2_in.px1 = rmg_pkg::PROD_W'(s1_ff.x1) * rmg_pkg::PROD_W'(cfg.span_y);
      s2_in.qy0 = rmg_pkg::PROD_W'(s1_ff.y0) * rmg_pkg::PROD_W'(cfg.span_x);
      s2_in.qy1 = rmg_pkg::PROD_W'(s1_ff.y1) * rmg_pkg::PROD_W'(cfg.span_x);
      gray_prod = rmg_pkg::GRAY_PROD_W'(s1_ff.sum)
                * rmg_pkg::GRAY_PROD_W'(rmg_pkg::GRAY_RECIP);
      s2_in.mean  = gray_prod[rmg_pkg::GRAY_SHIFT +: rmg_pkg::CHAN_W];
      s2_in.blue  = s1_ff.blue;
      s2_in.green = s1_ff.green;
      s2_in.red   = s1_ff.red;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

/* design/rmg_back.sv */
// ----------------------------------------------------------------------------
// Region-masked grayscale back stages
// Stage 3 squares the scaled offsets and settles the diamond test.
// Stage 4 compares the circle sums against (a*b)^2, picks the region by
// mode and forms the result pixel in the output register.
// ----------------------------------------------------------------------------
module rmg_back (
   input  logic                  clock,
   input  rmg_pkg::pipe_ctl_type ctl,
   input  rmg_pkg::cfg_type      cfg,
   input  rmg_pkg::s2_type       s2,
   output rmg_pkg::out_type      result
);

   localparam int LIN_W  = rmg_pkg::PROD_W + 1;
   localparam int DIST_W = rmg_pkg::SQ_W + 1;

   rmg_pkg::s3_type  s3_in, s3_ff;
   rmg_pkg::out_type out_in, out_ff;

   logic [DIST_W-1:0] d00, d10, d01, d11, lim;
   logic              beyond00, beyond10, beyond01, beyond11;
   logic              gray;

   // Squares and the linear diamond sum.
   always_comb begin
      s3_in.sx0 = rmg_pkg::SQ_W'(s2.px0) * rmg_pkg::SQ_W'(s2.px0);
      s3_in.sx1 = rmg_pkg::SQ_W'(s2.px1) * rmg_pkg::SQ_W'(s2.px1);
      s3_in.sy0 = rmg_pkg::SQ_W'(s2.qy0) * rmg_pkg::SQ_W'(s2.qy0);
      s3_in.sy1 = rmg_pkg::SQ_W'(s2.qy1) * rmg_pkg::SQ_W'(s2.qy1);
      s3_in.diamond_out = (LIN_W'(s2.px0) + LIN_W'(s2.qy0)) > LIN_W'(cfg.ab);
      s3_in.mean  = s2.mean;
      s3_in.blue  = s2.blue;
      s3_in.green = s2.green;
      s3_in.red   = s2.red;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s3) begin
         s3_ff <= s3_in;
      end
   end

   // Distance sums for each pairing of x and y offsets.
   always_comb begin
      lim = DIST_W'(cfg.ab_sq);
      d00 = DIST_W'(s3_ff.sx0) + DIST_W'(s3_ff.sy0);
      d10 = DIST_W'(s3_ff.sx1) + DIST_W'(s3_ff.sy0);
      d01 = DIST_W'(s3_ff.sx0) + DIST_W'(s3_ff.sy1);
      d11 = DIST_W'(s3_ff.sx1) + DIST_W'(s3_ff.sy1);
      beyond00 = d00 > lim;
      beyond10 = d10 > lim;
      beyond01 = d01 > lim;
      beyond11 = d11 > lim;
   end

   // Region decision; the unused mode code grays nothing.
   always_comb begin
      case (cfg.mode)
         rmg_pkg::MODE_DIAMOND: gray = s3_ff.diamond_out;
         rmg_pkg::MODE_CORNERS: gray = beyond00 && beyond10 && beyond01 && beyond11;
         rmg_pkg::MODE_CIRCLE:  gray = beyond00;
         default:               gray = 1'b0;
      endcase
      out_in.made_gray = gray;
      out_in.blue  = gray ? s3_ff.mean : s3_ff.blue;
      out_in.green = gray ? s3_ff.mean : s3_ff.green;
      out_in.red   = gray ? s3_ff.mean : s3_ff.red;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s4) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

/* design/region_masked_grayscale.sv */
// ----------------------------------------------------------------------------
// Region-masked grayscale
// Grays pixels that lie outside a diamond, four corner circles or a centred
// circle, with the shape scaled to the configured frame size.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Payload
//  req_     in   req_valid/req_ready    column, row, blue_in, green_in, red_in
//  rsp_     out  rsp_valid/rsp_ready    blue_out, green_out, red_out, made_gray
//  csr_     in   csr_we                 csr_index, csr_wdata
//
//  One request per cycle unless the output stalls.
//  The four stages are offsets, scaling products, squares, and compare/select.
//  Each stage loads whenever it is empty or the next stage is moving, so
//  bubbles close up while the output is stalled.
//  Synchronous reset empties the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
module region_masked_grayscale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rmg_pkg::COORD_W-1:0]   req_column,
   input  logic [rmg_pkg::COORD_W-1:0]   req_row,
   input  logic [rmg_pkg::CHAN_W-1:0]    req_blue_in,
   input  logic [rmg_pkg::CHAN_W-1:0]    req_green_in,
   input  logic [rmg_pkg::CHAN_W-1:0]    req_red_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rmg_pkg::CHAN_W-1:0]    rsp_blue_out,
   output logic [rmg_pkg::CHAN_W-1:0]    rsp_green_out,
   output logic [rmg_pkg::CHAN_W-1:0]    rsp_red_out,
   output logic                          rsp_made_gray,
   input  logic                          csr_we,
   input  logic [rmg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rmg_pkg::DIM_W-1:0]     csr_wdata
);

   rmg_pkg::cfg_type      cfg;
   rmg_pkg::pipe_ctl_type ctl;
   rmg_pkg::s2_type       s2;
   rmg_pkg::out_type      result;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   // Each stage advances when it is empty or its successor takes its data.
   always_comb begin
      ctl.load_s4 = !s4_valid_ff || rsp_ready;
      ctl.load_s3 = !s3_valid_ff || ctl.load_s4;
      ctl.load_s2 = !s2_valid_ff || ctl.load_s3;
      ctl.load_s1 = !s1_valid_ff || ctl.load_s2;
   end

   assign req_ready = ctl.load_s1;

   // Valid bits travel alongside the stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (ctl.load_s1) s1_valid_ff <= req_valid;
         if (ctl.load_s2) s2_valid_ff <= s1_valid_ff;
         if (ctl.load_s3) s3_valid_ff <= s2_valid_ff;
         if (ctl.load_s4) s4_valid_ff <= s3_valid_ff;
      end
   end

   rmg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rmg_front u_front (
      .clock    (clock),
      .ctl      (ctl),
      .cfg      (cfg),
      .column   (req_column),
      .row      (req_row),
      .blue_in  (req_blue_in),
      .green_in (req_green_in),
      .red_in   (req_red_in),
      .s2       (s2)
   );

   rmg_back u_back (
      .clock  (clock),
      .ctl    (ctl),
      .cfg    (cfg),
      .s2     (s2),
      .result (result)
   );

   assign rsp_valid     = s4_valid_ff;
   assign rsp_blue_out  = result.blue;
   assign rsp_green_out = result.green;
   assign rsp_red_out   = result.red;
   assign rsp_made_gray = result.made_gray;

endmodule

/* design/rmg_checker.sv */
// ----------------------------------------------------------------------------
// Region-masked grayscale port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "region_masked_grayscale_macros.svh"

module rmg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rmg_pkg::CHAN_W-1:0] rsp_blue_out,
   input logic [rmg_pkg::CHAN_W-1:0] rsp_green_out,
   input logic [rmg_pkg::CHAN_W-1:0] rsp_red_out,
   input logic                       rsp_made_gray
);

   // A stalled result stays put until it is taken.
   `RMG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_blue_out) && $stable(rsp_green_out) && $stable(rsp_red_out) && $stable(rsp_made_gray), "stalled result changed")

   // A grayed pixel carries the same mean on all three channels.
   `RMG_ASSERT_NOW(a_gray_equal, clock, reset, rsp_valid && rsp_made_gray, (rsp_blue_out == rsp_green_out) && (rsp_green_out == rsp_red_out), "grayed pixel has unequal channels")

   // With no result pending the pipeline can always take a request.
   `RMG_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "request refused while output is empty")

   // Reset leaves no result behind.
   `RMG_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")

endmodule

bind region_masked_grayscale rmg_checker u_rmg_checker (.*);
